>>> hw/rtl/cpt_pkg.sv
// Shared types, constants and helpers for the conveyor pile tracker.
package cpt_pkg;

  localparam int POS_W     = 32;
  localparam int VOL_W     = 32;
  localparam int LEN_W     = 31;
  localparam int GAIN_W    = 17;
  localparam int SCALE_W   = 16;
  localparam int DV_W      = 24;
  localparam int ADD_W     = DV_W + 1;
  localparam int WIDE_W    = 49;
  localparam int NUM_W     = 64;
  localparam int DIV_STEPS = 64;
  localparam int CNT_W     = 6;
  localparam int IN_W      = 56;
  localparam int OUT_W     = 200;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int ROT_SHIFT = 10;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam wide_t POS_MAX = wide_t'(signed'(32'h7fffffff));
  localparam wide_t POS_MIN = wide_t'(signed'(32'h80000000));

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED_VOL   = 3'd0,
    REG_CAP_VOL    = 3'd1,
    REG_SEED_FP    = 3'd2,
    REG_CAP_LEN    = 3'd3,
    REG_OFF_LEN    = 3'd4,
    REG_GAIN       = 3'd5,
    REG_BELT_SCALE = 3'd6
  } cfg_reg_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL, OP_BELT, OP_VADD, OP_BACK, OP_CUT,
    OP_PMUL, OP_DIV, OP_PWB, OP_FCHK, OP_FMUL, OP_TGT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic pdiv;
    logic fdiv;
    logic out_free;
  } stat_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [POS_W-1:0] sat32(input wide_t v);
    logic signed [POS_W-1:0] r;
    if (v > POS_MAX) r = POS_MAX[POS_W-1:0];
    else if (v < POS_MIN) r = POS_MIN[POS_W-1:0];
    else r = v[POS_W-1:0];
    return r;
  endfunction

  function automatic wide_t sx(input logic signed [POS_W-1:0] v);
    return wide_t'(v);
  endfunction

  function automatic wide_t zx(input logic [VOL_W-1:0] v);
    return wide_t'({1'b0, v});
  endfunction

endpackage

>>> hw/rtl/cpt_ctrl.sv
// Sequencer for the pile tracker: steps one request through the datapath.
module cpt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  cpt_pkg::stat_t stat,
  output cpt_pkg::cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_IDLE = 13'h0001,
    S_MUL  = 13'h0002,
    S_BELT = 13'h0004,
    S_VADD = 13'h0008,
    S_BACK = 13'h0010,
    S_CUT  = 13'h0020,
    S_PMUL = 13'h0040,
    S_PDIV = 13'h0080,
    S_PWB  = 13'h0100,
    S_FCHK = 13'h0200,
    S_FMUL = 13'h0400,
    S_FDIV = 13'h0800,
    S_TGT  = 13'h1000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [cpt_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      cnt_last;

  assign cnt_last  = (cnt_r == cpt_pkg::CNT_W'(cpt_pkg::DIV_STEPS - 1));
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = cpt_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = cpt_pkg::OP_LOAD;
          state_nxt = S_MUL;
        end
      end
      S_MUL:  begin cmd.op = cpt_pkg::OP_MUL;  state_nxt = S_BELT; end
      S_BELT: begin cmd.op = cpt_pkg::OP_BELT; state_nxt = S_VADD; end
      S_VADD: begin cmd.op = cpt_pkg::OP_VADD; state_nxt = S_BACK; end
      S_BACK: begin cmd.op = cpt_pkg::OP_BACK; state_nxt = S_CUT;  end
      S_CUT:  begin cmd.op = cpt_pkg::OP_CUT;  state_nxt = S_PMUL; end
      S_PMUL: begin
        if (stat.pdiv) begin
          cmd.op    = cpt_pkg::OP_PMUL;
          state_nxt = S_PDIV;
        end else begin
          state_nxt = S_FCHK;
        end
      end
      S_PDIV: begin
        cmd.op  = cpt_pkg::OP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) state_nxt = S_PWB;
      end
      S_PWB:  begin cmd.op = cpt_pkg::OP_PWB;  state_nxt = S_FCHK; end
      S_FCHK: begin cmd.op = cpt_pkg::OP_FCHK; state_nxt = S_FMUL; end
      S_FMUL: begin
        if (stat.fdiv) begin
          cmd.op    = cpt_pkg::OP_FMUL;
          state_nxt = S_FDIV;
        end else begin
          state_nxt = S_TGT;
        end
      end
      S_FDIV: begin
        cmd.op  = cpt_pkg::OP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) state_nxt = S_TGT;
      end
      S_TGT: begin
        // hold until the result register is free
        if (stat.out_free) begin
          cmd.op    = cpt_pkg::OP_TGT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/cpt_dp.sv
// Datapath: configuration, pile state, multipliers, shared divider, result register.
module cpt_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cpt_pkg::cmd_t                  cmd,
  output cpt_pkg::stat_t                 stat,
  input  logic [cpt_pkg::IN_W-1:0]       in_tdata,
  input  logic                           cfg_valid,
  input  logic [cpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpt_pkg::CFG_W-1:0]      cfg_data,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cpt_pkg::OUT_W-1:0]      out_tdata
);

  // configuration
  logic [cpt_pkg::VOL_W-1:0]   seed_vol_r, cap_vol_r;
  logic [cpt_pkg::LEN_W-1:0]   seed_fp_r, cap_len_r, off_len_r;
  logic [cpt_pkg::GAIN_W-1:0]  gain_r;
  logic [cpt_pkg::SCALE_W-1:0] scale_r;

  // request and pile state
  logic [cpt_pkg::DV_W-1:0]         dv_r, dv_nxt;
  logic signed [cpt_pkg::POS_W-1:0] rot_r, rot_nxt;
  cpt_pkg::wide_t                   prod_r, prod_nxt;
  logic [cpt_pkg::ADD_W-1:0]        added_r, added_nxt;
  logic signed [cpt_pkg::POS_W-1:0] belt_r, belt_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [cpt_pkg::VOL_W-1:0]        vol_r, vol_nxt;
  logic [cpt_pkg::POS_W-1:0]        pa_r, pa_nxt;
  logic                             pdiv_r, pdiv_nxt, fdiv_r, fdiv_nxt;
  logic                             vfull_r, vfull_nxt, lfull_r, lfull_nxt;
  logic                             hold_r, hold_nxt;

  // divider
  logic [cpt_pkg::NUM_W-1:0] num_r, num_nxt;
  logic [cpt_pkg::VOL_W-1:0] den_r, den_nxt, rem_r, rem_nxt;

  // result register
  logic [cpt_pkg::OUT_W-1:0] out_data_r, out_data_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic [cpt_pkg::GAIN_W-1:0]      gain_eff;
  logic [cpt_pkg::DV_W+cpt_pkg::GAIN_W-1:0] gprod;
  logic [cpt_pkg::VOL_W:0]         vsum, dsh;
  cpt_pkg::wide_t                  b, h, t, occ, cutoff, fillw, mt, ot;
  logic signed [cpt_pkg::POS_W-1:0] mtgt, otgt;

  assign gain_eff = gain_r[cpt_pkg::GAIN_W-1] ? cpt_pkg::GAIN_ONE : gain_r;
  assign gprod    = (cpt_pkg::DV_W+cpt_pkg::GAIN_W)'(dv_r) *
                    (cpt_pkg::DV_W+cpt_pkg::GAIN_W)'(gain_eff);
  assign b        = cpt_pkg::sx(belt_r);
  assign h        = cpt_pkg::sx(head_r);
  assign t        = cpt_pkg::sx(tail_r);
  assign occ      = h - t;
  assign cutoff   = b - cpt_pkg::zx(cpt_pkg::VOL_W'(off_len_r));
  assign vsum     = {1'b0, vol_r} + (cpt_pkg::VOL_W+1)'(added_r);
  assign dsh      = {rem_r, num_r[cpt_pkg::NUM_W-1]};

  // target arithmetic
  always_comb begin
    fillw = vfull_r ? cpt_pkg::zx(cpt_pkg::VOL_W'(cap_len_r))
                    : cpt_pkg::zx(cpt_pkg::VOL_W'(num_r[cpt_pkg::LEN_W-1:0]));
    mt = t + fillw;
    if (mt < b) mt = b;
    ot = h + cpt_pkg::zx(cpt_pkg::VOL_W'(off_len_r));
    if (ot < b) ot = b;
    mtgt = hold_r ? belt_r : cpt_pkg::sat32(mt);
    otgt = (occ > 0) ? cpt_pkg::sat32(ot) : belt_r;
  end

  always_comb begin
    dv_nxt        = dv_r;
    rot_nxt       = rot_r;
    prod_nxt      = prod_r;
    added_nxt     = added_r;
    belt_nxt      = belt_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    vol_nxt       = vol_r;
    pa_nxt        = pa_r;
    pdiv_nxt      = pdiv_r;
    fdiv_nxt      = fdiv_r;
    vfull_nxt     = vfull_r;
    lfull_nxt     = lfull_r;
    hold_nxt      = hold_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (cmd.op)
      cpt_pkg::OP_LOAD: begin
        dv_nxt  = in_tdata[cpt_pkg::DV_W-1:0];
        rot_nxt = signed'(in_tdata[cpt_pkg::DV_W +: cpt_pkg::POS_W]);
      end
      // belt product and gain product in parallel
      cpt_pkg::OP_MUL: begin
        prod_nxt  = cpt_pkg::sx(rot_r) * cpt_pkg::zx(cpt_pkg::VOL_W'(scale_r));
        added_nxt = gprod[cpt_pkg::DV_W+cpt_pkg::GAIN_W-1:16];
      end
      cpt_pkg::OP_BELT: belt_nxt = cpt_pkg::sat32(prod_r >>> cpt_pkg::ROT_SHIFT);
      // seed or extend the pile, add the kept volume
      cpt_pkg::OP_VADD: begin
        if (dv_r != '0) begin
          if (vol_r == '0) begin
            tail_nxt = cpt_pkg::sat32(b - cpt_pkg::zx(cpt_pkg::VOL_W'(seed_fp_r)));
            head_nxt = belt_r;
          end else if (b > h) begin
            head_nxt = belt_r;
            if (b - t > cpt_pkg::zx(cpt_pkg::VOL_W'(cap_len_r)))
              tail_nxt = cpt_pkg::sat32(b - cpt_pkg::zx(cpt_pkg::VOL_W'(cap_len_r)));
          end
          vol_nxt = vsum[cpt_pkg::VOL_W] ? '1 : vsum[cpt_pkg::VOL_W-1:0];
        end
      end
      // follow the belt backward; an empty pile sits at the belt
      cpt_pkg::OP_BACK: begin
        if (vol_r != '0) begin
          if (h > b) begin
            head_nxt = belt_r;
            tail_nxt = cpt_pkg::sat32(b - occ);
          end
        end else begin
          head_nxt = belt_r;
          tail_nxt = belt_r;
        end
      end
      // discharge cutoff: full or partial offload
      cpt_pkg::OP_CUT: begin
        pdiv_nxt = 1'b0;
        if (vol_r != '0) begin
          if (h < cutoff) begin
            vol_nxt  = '0;
            head_nxt = belt_r;
            tail_nxt = belt_r;
          end else if (t < cutoff) begin
            pdiv_nxt = 1'b1;
            pa_nxt   = cpt_pkg::POS_W'(h - cutoff);
            den_nxt  = cpt_pkg::VOL_W'(occ);
            tail_nxt = cpt_pkg::sat32(cutoff);
          end
        end
      end
      cpt_pkg::OP_PMUL: begin
        num_nxt = cpt_pkg::NUM_W'(vol_r) * cpt_pkg::NUM_W'(pa_r);
        rem_nxt = '0;
      end
      // one restoring division step
      cpt_pkg::OP_DIV: begin
        if (dsh >= {1'b0, den_r}) begin
          rem_nxt = cpt_pkg::VOL_W'(dsh - {1'b0, den_r});
          num_nxt = {num_r[cpt_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = dsh[cpt_pkg::VOL_W-1:0];
          num_nxt = {num_r[cpt_pkg::NUM_W-2:0], 1'b0};
        end
      end
      cpt_pkg::OP_PWB: vol_nxt = num_r[cpt_pkg::VOL_W-1:0];
      // flags and whether the mining fill needs a division
      cpt_pkg::OP_FCHK: begin
        vfull_nxt = (vol_r >= cap_vol_r);
        lfull_nxt = (occ >= cpt_pkg::zx(cpt_pkg::VOL_W'(cap_len_r)));
        hold_nxt  = (vol_r < seed_vol_r) &&
                    (occ <= cpt_pkg::zx(cpt_pkg::VOL_W'(seed_fp_r)));
        fdiv_nxt  = !hold_nxt && !vfull_nxt;
      end
      cpt_pkg::OP_FMUL: begin
        num_nxt = cpt_pkg::NUM_W'(vol_r) * cpt_pkg::NUM_W'(cap_len_r);
        den_nxt = cap_vol_r;
        rem_nxt = '0;
      end
      cpt_pkg::OP_TGT: begin
        out_data_nxt  = {6'd0, otgt, mtgt, lfull_r, vfull_r, tail_r, head_r, belt_r, vol_r};
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_vol_r  <= '0;
      cap_vol_r   <= 32'd1;
      seed_fp_r   <= '0;
      cap_len_r   <= 31'd1;
      off_len_r   <= '0;
      gain_r      <= cpt_pkg::GAIN_ONE;
      scale_r     <= '0;
      belt_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      vol_r       <= '0;
      pdiv_r      <= 1'b0;
      fdiv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          cpt_pkg::REG_SEED_VOL:   seed_vol_r <= cfg_data;
          cpt_pkg::REG_CAP_VOL:    cap_vol_r  <= cfg_data;
          cpt_pkg::REG_SEED_FP:    seed_fp_r  <= cfg_data[cpt_pkg::LEN_W-1:0];
          cpt_pkg::REG_CAP_LEN:    cap_len_r  <= cfg_data[cpt_pkg::LEN_W-1:0];
          cpt_pkg::REG_OFF_LEN:    off_len_r  <= cfg_data[cpt_pkg::LEN_W-1:0];
          cpt_pkg::REG_GAIN:       gain_r     <= cfg_data[cpt_pkg::GAIN_W-1:0];
          cpt_pkg::REG_BELT_SCALE: scale_r    <= cfg_data[cpt_pkg::SCALE_W-1:0];
          default: ;
        endcase
      end
      belt_r      <= belt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      vol_r       <= vol_nxt;
      pdiv_r      <= pdiv_nxt;
      fdiv_r      <= fdiv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dv_r       <= dv_nxt;
    rot_r      <= rot_nxt;
    prod_r     <= prod_nxt;
    added_r    <= added_nxt;
    pa_r       <= pa_nxt;
    vfull_r    <= vfull_nxt;
    lfull_r    <= lfull_nxt;
    hold_r     <= hold_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign stat.pdiv     = pdiv_r;
  assign stat.fdiv     = fdiv_r;
  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

endmodule

>>> hw/rtl/conveyor_pile_tracker.sv
// Top level of the conveyor pile tracker: controller plus datapath.
//
// Input stream (in_*): one request per motor sample, carrying the added
// volume and the absolute belt motor position. Result stream (out_*): one
// result per request with stored volume, belt/head/tail positions, full
// flags and the mining and offload targets. Configuration (cfg_*): register
// writes, always ready, to be issued only while no request is in flight.
// Sequence after acceptance: multiply, belt, volume add, backward follow,
// cutoff, an optional partial offload division, flag check, an optional
// mining fill fraction division, and target. Both divisions run on one
// restoring divider that retires one quotient bit per cycle over 64 bits, and
// the block works on one request at a time: the next request can be taken
// in the cycle after the result is issued.
// A finished result sits in the output register; the next request is taken
// meanwhile, and its result waits until the receiver takes the previous one.
// Reset (rst_n low, synchronous) clears the pile state to zero, loads the
// register defaults and empties the output register.
module conveyor_pile_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [23:0] delta_volume, [55:24] motor_pos
  input  logic [cpt_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [31:0] stored_volume, [63:32] belt_position, [95:64] pile_head,
  // [127:96] pile_tail, [128] volume_full, [129] length_full,
  // [161:130] mining_target, [193:162] offload_target, [199:194] zero
  output logic [cpt_pkg::OUT_W-1:0]     out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpt_pkg::CFG_W-1:0]     cfg_data
);

  cpt_pkg::cmd_t  cmd;
  cpt_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  cpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cpt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
